// File: hdl/long_delay_step_timer_assert.svh
// Assertion macros used by the step timer top level.
`ifndef LONG_DELAY_STEP_TIMER_ASSERT_SVH
`define LONG_DELAY_STEP_TIMER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define LDST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("step timer check failed");

// Check that a condition implies another in the next cycle.
`define LDST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("step timer check failed");

`endif

// File: hdl/ldst_pkg.sv
// Shared types and constants for the long delay step timer.
package ldst_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int DELAY_W  = 32;
    localparam int MASK_W   = 2;
    localparam int PERIOD_W = 16;
    localparam int THRESH_W = 8;
    localparam int REMAIN_W = 33;
    localparam int MS_W     = 8;
    localparam int QUARTER_W = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd3;

    localparam logic REG_WRAP_PERIOD     = 1'b0;
    localparam logic REG_FORCE_THRESHOLD = 1'b1;
    localparam int   REG_SEL_BIT         = 2;

    localparam logic [PERIOD_W-1:0] WRAP_PERIOD_RST     = 16'd64000;
    localparam logic [THRESH_W-1:0] FORCE_THRESHOLD_RST = 8'd16;

    localparam logic [MS_W:0]        MS_PER_WRAP    = 9'd2;
    localparam logic [MS_W:0]        MS_PER_QUARTER = 9'd250;
    localparam logic [QUARTER_W:0]   QUARTERS_PER_SECOND = 4'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DELAY_W-1:0]  delay;
        logic [MASK_W-1:0]   clear_mask;
    } cmd_t;

    typedef struct packed {
        logic step_pulse;
        logic flag_quarter_second;
        logic flag_one_second;
        logic armed;
    } result_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] wrap_period;
        logic [THRESH_W-1:0] force_threshold;
    } cfg_t;

endpackage

// File: hdl/ldst_ifs.sv
// Valid/ready channel interfaces for timer commands and status items.
interface ldst_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ldst_pkg::ACTION_W-1:0] action;
    logic [ldst_pkg::DELAY_W-1:0]  delay;
    logic [ldst_pkg::MASK_W-1:0]   clear_mask;

    modport source (output valid, action, delay, clear_mask, input ready);
    modport sink   (input valid, action, delay, clear_mask, output ready);
endinterface

interface ldst_status_if;
    logic valid;
    logic ready;
    logic step_pulse;
    logic flag_quarter_second;
    logic flag_one_second;
    logic armed;

    modport source (output valid, step_pulse, flag_quarter_second, flag_one_second, armed,
                    input ready);
    modport sink   (input valid, step_pulse, flag_quarter_second, flag_one_second, armed,
                    output ready);
endinterface

// File: hdl/ldst_apb_regs.sv
// APB configuration registers: wrap period and force threshold.
module ldst_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ldst_pkg::PADDR_W-1:0]  paddr,
    input  logic [ldst_pkg::PDATA_W-1:0]  pwdata,
    output logic [ldst_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ldst_pkg::cfg_t                cfg
);
    import ldst_pkg::*;

    logic [PERIOD_W-1:0] wrap_period_reg;
    logic [THRESH_W-1:0] force_threshold_reg;
    logic                reg_sel;
    logic                wr_en;

    assign reg_sel = paddr[REG_SEL_BIT];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_period_reg     <= WRAP_PERIOD_RST;
            force_threshold_reg <= FORCE_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_WRAP_PERIOD:     wrap_period_reg     <= pwdata[PERIOD_W-1:0];
                REG_FORCE_THRESHOLD: force_threshold_reg <= pwdata[THRESH_W-1:0];
                default:             wrap_period_reg     <= wrap_period_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WRAP_PERIOD:     prdata = PDATA_W'(wrap_period_reg);
            REG_FORCE_THRESHOLD: prdata = PDATA_W'(force_threshold_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.wrap_period     = wrap_period_reg;
    assign cfg.force_threshold = force_threshold_reg;

endmodule

// File: hdl/ldst_core.sv
// Timer state and the single-pass update for one command item.
module ldst_core #(
    parameter int COUNTER_BITS = ldst_pkg::COUNTER_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  ldst_pkg::cmd_t    cmd,
    input  ldst_pkg::cfg_t    cfg,
    output ldst_pkg::result_t result
);
    import ldst_pkg::*;

    localparam int CW = COUNTER_BITS;

    logic [CW-1:0]        count_reg,   count_next;
    logic [REMAIN_W-1:0]  remain_reg,  remain_next;
    logic [CW-1:0]        cmp_reg,     cmp_next;
    logic                 armed_reg,   armed_next;
    logic [MS_W-1:0]      ms_reg,      ms_next;
    logic [QUARTER_W-1:0] quarter_reg, quarter_next;
    logic [1:0]           flags_reg,   flags_next;

    logic [PERIOD_W-1:0]  period;
    logic [REMAIN_W-1:0]  period_w;
    logic [CW:0]          count_inc;
    logic                 wrap;
    logic [MS_W:0]        ms_sum;
    logic [QUARTER_W:0]   quarter_sum;
    logic [MS_W-1:0]      ms_wrap;
    logic [QUARTER_W-1:0] quarter_wrap;
    logic [1:0]           flags_wrap;
    logic [REMAIN_W-1:0]  set_sum;
    logic                 pulse;

    assign period    = (cfg.wrap_period == '0) ? PERIOD_W'(1) : cfg.wrap_period;
    assign period_w  = REMAIN_W'(period);
    assign count_inc = {1'b0, count_reg} + (CW+1)'(1);
    assign wrap      = (REMAIN_W'(count_inc) >= period_w) || (count_reg == '1);
    assign set_sum   = REMAIN_W'(cmd.delay) + REMAIN_W'(count_reg);

    // slow clock advance on a wrap
    always_comb
    begin
        ms_sum       = {1'b0, ms_reg} + MS_PER_WRAP;
        quarter_sum  = {1'b0, quarter_reg};
        flags_wrap   = flags_reg;
        if (ms_sum >= MS_PER_QUARTER)
        begin
            ms_sum        = ms_sum - MS_PER_QUARTER;
            flags_wrap[0] = 1'b1;
            quarter_sum   = quarter_sum + (QUARTER_W+1)'(1);
            if (quarter_sum >= QUARTERS_PER_SECOND)
            begin
                quarter_sum   = quarter_sum - QUARTERS_PER_SECOND;
                flags_wrap[1] = 1'b1;
            end
        end
        ms_wrap      = ms_sum[MS_W-1:0];
        quarter_wrap = quarter_sum[QUARTER_W-1:0];
    end

    always_comb
    begin
        count_next   = count_reg;
        remain_next  = remain_reg;
        cmp_next     = cmp_reg;
        armed_next   = armed_reg;
        ms_next      = ms_reg;
        quarter_next = quarter_reg;
        flags_next   = flags_reg;
        pulse        = 1'b0;
        unique case (cmd.action)
            ACT_TICK:
            begin
                if (wrap)
                begin
                    count_next   = '0;
                    ms_next      = ms_wrap;
                    quarter_next = quarter_wrap;
                    flags_next   = flags_wrap;
                    if (remain_reg > period_w)
                    begin
                        remain_next = remain_reg - period_w;
                    end
                    else if (remain_reg != '0)
                    begin
                        cmp_next   = remain_reg[CW-1:0];
                        armed_next = 1'b1;
                    end
                end
                else
                begin
                    count_next = count_inc[CW-1:0];
                end
                if (armed_next && (count_next == cmp_next))
                begin
                    pulse       = 1'b1;
                    armed_next  = 1'b0;
                    remain_next = '0;
                end
            end
            ACT_SET:
            begin
                armed_next = 1'b0;
                if (cmd.delay == '0)
                begin
                    remain_next = '0;
                end
                else if (cmd.delay <= DELAY_W'(cfg.force_threshold))
                begin
                    pulse       = 1'b1;
                    remain_next = '0;
                end
                else
                begin
                    remain_next = set_sum;
                    if (cmd.delay <= DELAY_W'(period))
                    begin
                        cmp_next   = set_sum[CW-1:0];
                        armed_next = 1'b1;
                    end
                end
            end
            ACT_CLEAR:
            begin
                flags_next = flags_reg & ~cmd.clear_mask;
            end
            ACT_STOP:
            begin
                armed_next  = 1'b0;
                remain_next = '0;
            end
            default:
            begin
                pulse = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            remain_reg  <= '0;
            cmp_reg     <= '0;
            armed_reg   <= 1'b0;
            ms_reg      <= '0;
            quarter_reg <= '0;
            flags_reg   <= '0;
        end
        else if (step_en)
        begin
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            cmp_reg     <= cmp_next;
            armed_reg   <= armed_next;
            ms_reg      <= ms_next;
            quarter_reg <= quarter_next;
            flags_reg   <= flags_next;
        end
    end

    assign result.step_pulse          = pulse;
    assign result.flag_quarter_second = flags_next[0];
    assign result.flag_one_second     = flags_next[1];
    assign result.armed               = armed_next;

endmodule

// File: hdl/long_delay_step_timer.sv
// Top level of the long delay step timer: command/status pipeline and APB port.
// Pipeline: an accepted item passes the input register, then the status
// register fed by the state update, which holds its status item.
// Throughput: one item per cycle while the status side takes items; the status register frees as it is taken.
// Reset: rst_n clears all timer state and the valid flags of both stages, and restores the
// wrap period to 64000 and the force threshold to 16.
`include "long_delay_step_timer_assert.svh"

module long_delay_step_timer #(
    parameter int COUNTER_BITS = ldst_pkg::COUNTER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ldst_cmd_if.sink                      cmd,
    ldst_status_if.source                 status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ldst_pkg::PADDR_W-1:0]  paddr,
    input  logic [ldst_pkg::PDATA_W-1:0]  pwdata,
    output logic [ldst_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ldst_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd_reg;
    logic    cmd_valid_reg;
    result_t result;
    result_t status_reg;
    logic    status_valid_reg;
    logic    advance;

    ldst_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ldst_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .cmd     (cmd_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance   = cmd_valid_reg && (!status_valid_reg || status.ready);
    assign cmd.ready = !cmd_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg    <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                status_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                status_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.action     <= cmd.action;
            cmd_reg.delay      <= cmd.delay;
            cmd_reg.clear_mask <= cmd.clear_mask;
        end
        if (advance)
        begin
            status_reg <= result;
        end
    end

    assign status.valid               = status_valid_reg;
    assign status.step_pulse          = status_reg.step_pulse;
    assign status.flag_quarter_second = status_reg.flag_quarter_second;
    assign status.flag_one_second     = status_reg.flag_one_second;
    assign status.armed               = status_reg.armed;

    `LDST_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
        cmd_valid_reg && status_valid_reg && !status.ready, !cmd.ready)
    `LDST_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n,
        cmd.valid && cmd.ready, cmd_valid_reg)
    `LDST_ASSERT_NEXT(a_advance_gives_status, clk, rst_n,
        advance, status_valid_reg)
    `LDST_ASSERT_SAME(a_pulse_disarms, clk, rst_n,
        status_valid_reg && status_reg.step_pulse, !status_reg.armed)

endmodule
